### design/linear_probe_hash_set_top_macros.svh
// Assertion macros of the hash set controller.
// Depends on nothing; included by lphs_ctrl, which checks its own logic.
`ifndef LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/lphs_pkg.sv
// Shared types, codes and the home slot function of the linear probing hash set.
// Depends on nothing; used by every module of the block.
package lphs_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_DELTA   = 8'h20;

  // The smallest multiple of the table size that is not below 'A'.
  localparam int HOME_OFFSET = ((65 + TABLE_SLOTS - 1) / TABLE_SLOTS) * TABLE_SLOTS;
  localparam logic [9:0] HOME_BIAS = 10'(HOME_OFFSET - 65);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    RES_INSERTED = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_FULL     = 3'd2,
    RES_REMOVED  = 3'd3,
    RES_MISS     = 3'd4,
    RES_FOUND    = 3'd5,
    RES_ABSENT   = 3'd6
  } status_code_t;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_DELETED = 2'd1,
    TAG_USED    = 2'd2
  } tag_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
  } result_t;

  typedef struct packed {
    logic         load;
    logic         rewind;
    logic         advance;
    logic         write_used;
    logic         write_deleted;
    logic         emit;
    logic         take_slot;
    status_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       used;
    logic       match;
    logic       last;
    logic [1:0] action;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] home_slot(input logic [7:0] key);
    logic [7:0] k;
    logic [9:0] sum;
    k = key;
    if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z) begin
      k = k - CASE_DELTA;
    end
    sum = 10'(k) + HOME_BIAS;
    return IDX_W'(sum % TABLE_SLOTS);
  endfunction

endpackage

### design/lphs_datapath.sv
// Datapath of the hash set: slot table, probe index and count, result register.
// Depends on lphs_pkg; driven by commands from lphs_ctrl.
module lphs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lphs_pkg::request_t   request,
  input  lphs_pkg::ctrl_cmd_t  cmd,
  output lphs_pkg::dp_status_t stat,
  output logic                 done,
  output lphs_pkg::result_t    result
);

  lphs_pkg::tag_t                  tags [lphs_pkg::TABLE_SLOTS];
  logic [7:0]                      keys [lphs_pkg::TABLE_SLOTS];
  lphs_pkg::request_t              req;
  logic [lphs_pkg::IDX_W-1:0]      home;
  logic [lphs_pkg::IDX_W-1:0]      idx;
  logic [lphs_pkg::IDX_W-1:0]      idx_next;
  logic [lphs_pkg::IDX_W-1:0]      count;
  logic [lphs_pkg::IDX_W-1:0]      home_next;
  lphs_pkg::tag_t                  cur_tag;

  assign home_next = lphs_pkg::home_slot(request.key);
  assign idx_next  = (idx == lphs_pkg::LAST_IDX) ? '0 : idx + 1'b1;
  assign cur_tag   = tags[idx];

  assign stat.empty  = (cur_tag == lphs_pkg::TAG_EMPTY);
  assign stat.used   = (cur_tag == lphs_pkg::TAG_USED);
  assign stat.match  = (cur_tag == lphs_pkg::TAG_USED) && (keys[idx] == req.key);
  assign stat.last   = (count == lphs_pkg::LAST_IDX);
  assign stat.action = req.action;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= request;
      home  <= home_next;
      idx   <= home_next;
      count <= '0;
    end else if (cmd.rewind) begin
      idx   <= home;
      count <= '0;
    end else if (cmd.advance) begin
      idx   <= idx_next;
      count <= count + 1'b1;
    end
    if (cmd.write_used) begin
      keys[idx] <= req.key;
    end
    if (cmd.emit) begin
      result.status <= 3'(cmd.code);
      result.slot   <= cmd.take_slot ? 4'(idx) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
        tags[i] <= lphs_pkg::TAG_EMPTY;
      end
      done <= 1'b0;
    end else begin
      if (cmd.write_used) begin
        tags[idx] <= lphs_pkg::TAG_USED;
      end else if (cmd.write_deleted) begin
        tags[idx] <= lphs_pkg::TAG_DELETED;
      end
      done <= cmd.emit;
    end
  end

endmodule

### design/lphs_ctrl.sv
// Controller of the hash set: sequences the membership probe and the free slot probe.
// Depends on lphs_pkg and the assertion macros; steers lphs_datapath.
`include "linear_probe_hash_set_top_macros.svh"

module lphs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lphs_pkg::dp_status_t stat,
  output logic                 busy,
  output lphs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FIND = 3'b010,
    ST_FREE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = lphs_pkg::RES_ABSENT;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        if (stat.match) begin
          cmd.emit      = 1'b1;
          cmd.take_slot = 1'b1;
          state_next    = ST_IDLE;
          priority if (stat.action == lphs_pkg::ACT_INSERT) begin
            cmd.code = lphs_pkg::RES_PRESENT;
          end else if (stat.action == lphs_pkg::ACT_REMOVE) begin
            cmd.code          = lphs_pkg::RES_REMOVED;
            cmd.write_deleted = 1'b1;
          end else begin
            cmd.code = lphs_pkg::RES_FOUND;
          end
        end else if (stat.empty || stat.last) begin
          if (stat.action == lphs_pkg::ACT_INSERT) begin
            cmd.rewind = 1'b1;
            state_next = ST_FREE;
          end else begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
            cmd.code   = (stat.action == lphs_pkg::ACT_REMOVE) ?
                         lphs_pkg::RES_MISS : lphs_pkg::RES_ABSENT;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_FREE: begin
        if (!stat.used) begin
          cmd.emit       = 1'b1;
          cmd.take_slot  = 1'b1;
          cmd.write_used = 1'b1;
          cmd.code       = lphs_pkg::RES_INSERTED;
          state_next     = ST_IDLE;
        end else if (stat.last) begin
          cmd.emit   = 1'b1;
          cmd.code   = lphs_pkg::RES_FULL;
          state_next = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LPHS_ASSERT_NEXT(a_emit_then_idle, clk, rst, cmd.emit, state == ST_IDLE, "result without return to idle")
  `LPHS_ASSERT_SAME(a_write_with_emit, clk, rst, cmd.write_used || cmd.write_deleted, cmd.emit, "table write without a result")
  `LPHS_ASSERT_SAME(a_load_in_idle, clk, rst, cmd.load, (state == ST_IDLE) && start, "request loaded outside idle")
  `LPHS_ASSERT_NEXT(a_rewind_to_free, clk, rst, cmd.rewind, state == ST_FREE, "free slot probe not started")

endmodule

### design/linear_probe_hash_set_top.sv
// Top level of the linear probing hash set of byte keys.
// Depends on lphs_pkg, lphs_ctrl and lphs_datapath.
//
//   Channel   Handshake          Payload
//   request   start, busy        request.action, request.key
//   result    done (one cycle)   result.status, result.slot
//
// A request is taken when start is high and busy is low; its result beat follows
// the probes of the slot table, one probe of the slot table per cycle.
// The membership probe visits up to TABLE_SLOTS slots, and an insert of an absent key
// runs a second probe of up to TABLE_SLOTS slots for a free slot.
// Reset empties every slot at once. The receiver cannot stall: done is high for
// exactly one cycle, and a new request may be taken in that same cycle.
module linear_probe_hash_set_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lphs_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output lphs_pkg::result_t  result
);

  lphs_pkg::ctrl_cmd_t  cmd;
  lphs_pkg::dp_status_t stat;

  lphs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  lphs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

### tb/sv/tb_linear_probe_hash_set_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the linear probing hash set: directed beats, then random
// episodes of insert, remove and lookup traffic against a table model kept in the bench.
// Depends on lphs_pkg and linear_probe_hash_set_top.
module tb_linear_probe_hash_set_top;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1920;
  localparam int SETTLE_CYCLES = 2 * lphs_pkg::TABLE_SLOTS + 4;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int REPORT_LIMIT = 10;

  typedef logic [7:0] key_queue_t[$];

  class hash_set_scoreboard;
    lphs_pkg::tag_t    slot_tag[lphs_pkg::TABLE_SLOTS];
    logic [7:0]        slot_key[lphs_pkg::TABLE_SLOTS];
    lphs_pkg::result_t owed_results[$];
    int                failures;
    int                results_checked;
    int                status_seen[8];

    function new();
      foreach (slot_tag[i]) begin
        slot_tag[i] = lphs_pkg::TAG_EMPTY;
        slot_key[i] = '0;
      end
      failures = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned home_of(logic [7:0] key);
      int k;
      int r;
      k = key;
      if (key >= lphs_pkg::CHAR_LOWER_A && key <= lphs_pkg::CHAR_LOWER_Z) begin
        k = k - int'(lphs_pkg::CASE_DELTA);
      end
      r = (k - int'(lphs_pkg::CHAR_UPPER_A)) % lphs_pkg::TABLE_SLOTS;
      if (r < 0) begin
        r = r + lphs_pkg::TABLE_SLOTS;
      end
      return r;
    endfunction

    function bit locate(logic [7:0] key, output int unsigned where);
      int unsigned idx;
      where = 0;
      idx = home_of(key);
      for (int n = 0; n < lphs_pkg::TABLE_SLOTS; n++) begin
        if (slot_tag[idx] == lphs_pkg::TAG_EMPTY) begin
          return 1'b0;
        end
        if (slot_tag[idx] == lphs_pkg::TAG_USED && slot_key[idx] == key) begin
          where = idx;
          return 1'b1;
        end
        idx = (idx + 1) % lphs_pkg::TABLE_SLOTS;
      end
      return 1'b0;
    endfunction

    function lphs_pkg::result_t apply_to_table(lphs_pkg::request_t req);
      lphs_pkg::result_t res;
      int unsigned       where;
      int unsigned       idx;
      bit                hit;
      res.slot = '0;
      hit = locate(req.key, where);
      case (req.action)
        lphs_pkg::ACT_INSERT: begin
          if (hit) begin
            res.status = lphs_pkg::RES_PRESENT;
            res.slot = 4'(where);
          end else begin
            res.status = lphs_pkg::RES_FULL;
            idx = home_of(req.key);
            for (int n = 0; n < lphs_pkg::TABLE_SLOTS; n++) begin
              if (slot_tag[idx] != lphs_pkg::TAG_USED) begin
                slot_tag[idx] = lphs_pkg::TAG_USED;
                slot_key[idx] = req.key;
                res.status = lphs_pkg::RES_INSERTED;
                res.slot = 4'(idx);
                break;
              end
              idx = (idx + 1) % lphs_pkg::TABLE_SLOTS;
            end
          end
        end
        lphs_pkg::ACT_REMOVE: begin
          if (hit) begin
            slot_tag[where] = lphs_pkg::TAG_DELETED;
            res.status = lphs_pkg::RES_REMOVED;
            res.slot = 4'(where);
          end else begin
            res.status = lphs_pkg::RES_MISS;
          end
        end
        default: begin
          if (hit) begin
            res.status = lphs_pkg::RES_FOUND;
            res.slot = 4'(where);
          end else begin
            res.status = lphs_pkg::RES_ABSENT;
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(lphs_pkg::request_t req);
      owed_results.push_back(apply_to_table(req));
    endfunction

    function void check_result(lphs_pkg::result_t got);
      lphs_pkg::result_t want;
      results_checked++;
      status_seen[got.status]++;
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] result beat with nothing outstanding: status %0d slot %0d",
                   $realtime, got.status, got.slot);
        end
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                   $realtime, want.status, want.slot, got.status, got.slot);
        end
      end
    endfunction

    function void close_out();
      if (owed_results.size() != 0) begin
        failures++;
        $display("%0d expected result beats never arrived", owed_results.size());
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function key_queue_t stored_keys();
      key_queue_t keys;
      foreach (slot_tag[i]) begin
        if (slot_tag[i] == lphs_pkg::TAG_USED) begin
          keys.push_back(slot_key[i]);
        end
      end
      return keys;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  lphs_pkg::request_t request;
  logic               busy;
  logic               done;
  lphs_pkg::result_t  result;

  hash_set_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;

  linear_probe_hash_set_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result(result);
      end
      if (start && !busy) begin
        sb.note_request(request);
      end
    end
  end

  task automatic issue(input logic [1:0] act, input logic [7:0] key);
    lphs_pkg::request_t req;
    int                 gap;
    req.action = act;
    req.key = key;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_episode();
    logic [7:0] pool[$];
    key_queue_t stored;
    int         kind;
    int         len;
    int         pool_len;
    int         base;
    int         pick;
    int         insert_pct;
    int         remove_pct;
    logic [1:0] act;
    logic [7:0] key;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      settle();
      stored = sb.stored_keys();
      foreach (stored[i]) begin
        if ($urandom_range(0, 7) != 0) begin
          issue(lphs_pkg::ACT_REMOVE, stored[i]);
        end
      end
      return;
    end
    pool_len = $urandom_range(3, 24);
    base = $urandom_range(0, 255);
    for (int i = 0; i < pool_len; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        pool.push_back(8'(base + 16 * $urandom_range(0, 15) + $urandom_range(0, 2)));
      end else begin
        pool.push_back(8'($urandom));
      end
    end
    insert_pct = (kind <= 4) ? 60 : 35;
    remove_pct = (kind <= 4) ? 15 : 30;
    len = $urandom_range(10, 60);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (kind == 1) begin
        act = 2'($urandom_range(0, 3));
        key = 8'($urandom);
      end else begin
        key = pool[$urandom_range(0, pool_len - 1)];
        if (pick < insert_pct) begin
          act = lphs_pkg::ACT_INSERT;
        end else if (pick < insert_pct + remove_pct) begin
          act = lphs_pkg::ACT_REMOVE;
        end else if (pick < 96) begin
          act = lphs_pkg::ACT_LOOKUP;
        end else begin
          act = ACT_SPARE;
        end
      end
      issue(act, key);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(lphs_pkg::ACT_INSERT, 8'h00);
    issue(lphs_pkg::ACT_INSERT, 8'hFF);
    issue(lphs_pkg::ACT_INSERT, "a");
    issue(lphs_pkg::ACT_INSERT, "A");
    issue(lphs_pkg::ACT_INSERT, "a");
    issue(lphs_pkg::ACT_LOOKUP, "A");
    issue(lphs_pkg::ACT_REMOVE, "a");
    issue(lphs_pkg::ACT_LOOKUP, "A");
    issue(lphs_pkg::ACT_REMOVE, "a");
    issue(ACT_SPARE, "A");
    issue(ACT_SPARE, "Z");
    issue(lphs_pkg::ACT_INSERT, ".");
    issue(lphs_pkg::ACT_INSERT, "?");
    issue(lphs_pkg::ACT_LOOKUP, "?");
    issue(lphs_pkg::ACT_LOOKUP, "z");
    issue(lphs_pkg::ACT_REMOVE, "A");
    issue(lphs_pkg::ACT_INSERT, "q");
    issue(lphs_pkg::ACT_LOOKUP, 8'hFF);
    settle();

    while (items_sent < ITEM_TARGET) begin
      run_episode();
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();

    $display("Sent %0d requests and checked %0d result beats.", items_sent,
             sb.results_checked);
    $display("Seen: inserted %0d present %0d full %0d removed %0d miss %0d found %0d absent %0d",
             sb.status_seen[lphs_pkg::RES_INSERTED], sb.status_seen[lphs_pkg::RES_PRESENT],
             sb.status_seen[lphs_pkg::RES_FULL], sb.status_seen[lphs_pkg::RES_REMOVED],
             sb.status_seen[lphs_pkg::RES_MISS], sb.status_seen[lphs_pkg::RES_FOUND],
             sb.status_seen[lphs_pkg::RES_ABSENT]);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d result beats outstanding.", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/lphs_pkg.sv
design/lphs_datapath.sv
design/lphs_ctrl.sv
design/linear_probe_hash_set_top.sv
tb/sv/tb_linear_probe_hash_set_top.sv
